// ----- rtl/core/ptra_pkg.sv -----
// shared types, constants and codes for the proportional tag range allocator
package ptra_pkg;

  // field widths
  localparam int KIND_W       = 2;
  localparam int FN_W         = 3;
  localparam int DESIRED_W    = 16;
  localparam int TAG_W        = 12;
  localparam int PASID_W      = 20;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 20;
  localparam int PROD_W       = TAG_W + DESIRED_W;

  // defaults and reset values
  localparam int NUM_FUNCTIONS_DEF = 8;
  localparam logic [TAG_W-1:0]   TAG_LIMIT_RESET   = TAG_W'(64);
  localparam logic [PASID_W-1:0] PASID_LIMIT_RESET = PASID_W'((1 << 15) - 1);

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_RECORD = 2'd0,
    KIND_RANGE  = 2'd1,
    KIND_PASID  = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAG_LIMIT   = 2'd0,
    REG_PASID_LIMIT = 2'd1
  } reg_idx_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SUM,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_STORE,
    ST_RESP
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch_item;
    logic rec_write;
    logic clear_acc;
    logic sel_walk;
    logic sum_add;
    logic idx_clr;
    logic idx_inc;
    logic grant_want;
    logic mul_load;
    logic div_step;
    logic store;
    logic set_done;
    logic load_out;
  } ptra_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              done;
    logic              idx_last;
    logic              want_zero;
    logic              fits;
    logic              div_last;
    logic              out_free;
  } ptra_stat_t;

endpackage

// ----- rtl/core/proportional_tag_range_allocator.sv -----
// top level of the proportional tag range allocator
// Shares a pool of tag_limit context tags among the functions of one device.
// Input channel (in_valid/in_ready) takes kind, function_index and
// desired_count; every transfer gives exactly one result on the output
// channel (out_valid/out_ready). Configuration writes arrive on the cfg
// channel (index 0 tag_limit, index 1 pasid_limit), always ready; the user
// must write idle only, the block does not enforce it. Record items, PASID
// queries and later range queries go from decode to the response state.
// The first tag range query runs the assignment: it sums the desired
// counts of all functions, then per function skips it if it has no demand,
// grants the desired count if the total fits, else multiplies and divides
// in a 12-step shared divider, and stores start and count. One item is
// worked on at a time; the next is accepted as soon as the previous result
// sits in the output register. If the receiver stalls, the result holds
// and the next item waits in the response state until the output register
// frees up. Synchronous reset clears all tables, the done flag and restores
// the configuration defaults (tag_limit 64, pasid_limit 32767).
module proportional_tag_range_allocator #(
  parameter int NUM_FUNCTIONS = ptra_pkg::NUM_FUNCTIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ptra_pkg::KIND_W-1:0]       kind,
  input  logic [ptra_pkg::FN_W-1:0]         function_index,
  input  logic [ptra_pkg::DESIRED_W-1:0]    desired_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ptra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptra_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic [ptra_pkg::TAG_W-1:0]        base_tag,
  output logic [ptra_pkg::TAG_W-1:0]        granted_count,
  output logic [ptra_pkg::DESIRED_W-1:0]    wanted_count,
  output logic [ptra_pkg::PASID_W-1:0]      pasid_count,
  output logic                              range_warning
);

  ptra_pkg::ptra_cmd_t  cmd;
  ptra_pkg::ptra_stat_t stat;

  // configuration writes never stall
  assign cfg_ready = 1'b1;

  ptra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptra_dp #(
    .NUM_FUNCTIONS (NUM_FUNCTIONS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .kind           (kind),
    .function_index (function_index),
    .desired_count  (desired_count),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .base_tag       (base_tag),
    .granted_count  (granted_count),
    .wanted_count   (wanted_count),
    .pasid_count    (pasid_count),
    .range_warning  (range_warning)
  );

endmodule

// ----- rtl/core/ptra_dp.sv -----
// datapath: tables, configuration registers, sum, multiply, divide and result register
module ptra_dp #(
  parameter int NUM_FUNCTIONS = ptra_pkg::NUM_FUNCTIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ptra_pkg::ptra_cmd_t               cmd,
  output ptra_pkg::ptra_stat_t              stat,
  input  logic [ptra_pkg::KIND_W-1:0]       kind,
  input  logic [ptra_pkg::FN_W-1:0]         function_index,
  input  logic [ptra_pkg::DESIRED_W-1:0]    desired_count,
  input  logic                              cfg_valid,
  input  logic [ptra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptra_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic [ptra_pkg::TAG_W-1:0]        base_tag,
  output logic [ptra_pkg::TAG_W-1:0]        granted_count,
  output logic [ptra_pkg::DESIRED_W-1:0]    wanted_count,
  output logic [ptra_pkg::PASID_W-1:0]      pasid_count,
  output logic                              range_warning
);

  localparam int TAG_W     = ptra_pkg::TAG_W;
  localparam int DESIRED_W = ptra_pkg::DESIRED_W;
  localparam int PASID_W   = ptra_pkg::PASID_W;
  localparam int FN_W      = ptra_pkg::FN_W;
  localparam int PROD_W_L  = ptra_pkg::PROD_W;
  localparam int IDX_W     = (NUM_FUNCTIONS > 1) ? $clog2(NUM_FUNCTIONS) : 1;
  localparam int TOTAL_W   = DESIRED_W + $clog2(NUM_FUNCTIONS);
  localparam int START_W   = TAG_W + $clog2(NUM_FUNCTIONS) + 1;
  localparam int DIV_W     = TOTAL_W + TAG_W;
  localparam int DCNT_W    = $clog2(TAG_W);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_FUNCTIONS - 1);
  localparam logic [DCNT_W-1:0] DIV_TOP  = DCNT_W'(TAG_W - 1);

  // configuration registers
  logic [TAG_W-1:0]   tag_limit;
  logic [PASID_W-1:0] pasid_limit;

  // captured item
  logic [ptra_pkg::KIND_W-1:0] item_kind;
  logic [FN_W-1:0]             item_fn;
  logic [DESIRED_W-1:0]        item_want;
  logic                        fn_valid;
  logic [IDX_W-1:0]            item_idx;

  // per-function tables
  logic [DESIRED_W-1:0] desired   [NUM_FUNCTIONS];
  logic [TAG_W-1:0]     start_tab [NUM_FUNCTIONS];
  logic [TAG_W-1:0]     count_tab [NUM_FUNCTIONS];
  logic                 done;

  // assignment working registers
  logic [IDX_W-1:0]   walk_idx;
  logic [TOTAL_W-1:0] total;
  logic [START_W-1:0] start_acc;
  logic [START_W-1:0] start_next;
  logic               warn;
  logic [TAG_W-1:0]   grant;
  logic [DIV_W-1:0]   rem;
  logic [DIV_W-1:0]   dsh;
  logic [DCNT_W-1:0]  div_cnt;
  logic [PROD_W_L-1:0] product;

  logic [IDX_W-1:0]     rd_idx;
  logic [DESIRED_W-1:0] rd_want;
  logic                 rem_ge;

  assign fn_valid = {1'b0, item_fn} < (FN_W + 1)'(NUM_FUNCTIONS);
  assign item_idx = item_fn[IDX_W-1:0];
  assign rd_idx   = cmd.sel_walk ? walk_idx : item_idx;
  assign rd_want  = desired[rd_idx];
  assign product  = PROD_W_L'(tag_limit) * PROD_W_L'(rd_want);
  assign rem_ge   = rem >= dsh;
  assign start_next = start_acc + START_W'(grant);

  // status towards the controller
  always_comb begin
    stat.kind      = item_kind;
    stat.done      = done;
    stat.idx_last  = walk_idx == LAST_IDX;
    stat.want_zero = rd_want == '0;
    stat.fits      = total <= TOTAL_W'(tag_limit);
    stat.div_last  = div_cnt == '0;
    stat.out_free  = !out_valid || out_ready;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_limit   <= ptra_pkg::TAG_LIMIT_RESET;
      pasid_limit <= ptra_pkg::PASID_LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == ptra_pkg::REG_TAG_LIMIT) begin
        tag_limit <= cfg_data[TAG_W-1:0];
      end else if (cfg_index == ptra_pkg::REG_PASID_LIMIT) begin
        pasid_limit <= cfg_data[PASID_W-1:0];
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_kind <= kind;
      item_fn   <= function_index;
      item_want <= desired_count;
    end
  end

  // tables and done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FUNCTIONS; i++) begin
        desired[i]   <= '0;
        start_tab[i] <= '0;
        count_tab[i] <= '0;
      end
      done <= 1'b0;
    end else begin
      if (cmd.rec_write && fn_valid) begin
        desired[item_idx] <= item_want;
      end
      if (cmd.store) begin
        start_tab[walk_idx] <= start_acc[TAG_W-1:0];
        count_tab[walk_idx] <= grant;
      end
      if (cmd.set_done) begin
        done <= 1'b1;
      end
    end
  end

  // walk index, running total and running start
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      walk_idx <= '0;
    end else if (cmd.idx_inc) begin
      walk_idx <= walk_idx + IDX_W'(1);
    end
    if (cmd.clear_acc) begin
      total     <= '0;
      start_acc <= '0;
    end else begin
      if (cmd.sum_add) begin
        total <= total + TOTAL_W'(rd_want);
      end
      if (cmd.store) begin
        start_acc <= start_next;
      end
    end
  end

  // warning flag, cleared for every new item
  always_ff @(posedge clk) begin
    if (rst || cmd.latch_item) begin
      warn <= 1'b0;
    end else if (cmd.store && start_next >= START_W'(tag_limit)) begin
      warn <= 1'b1;
    end
  end

  // grant: direct count, or restoring division of the product by the total
  always_ff @(posedge clk) begin
    if (cmd.grant_want) begin
      grant <= rd_want[TAG_W-1:0];
    end else if (cmd.mul_load) begin
      rem     <= DIV_W'(product);
      dsh     <= DIV_W'(total) << (TAG_W - 1);
      grant   <= '0;
      div_cnt <= DIV_TOP;
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem <= rem - dsh;
      end
      grant   <= {grant[TAG_W-2:0], rem_ge};
      dsh     <= dsh >> 1;
      div_cnt <= div_cnt - DCNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status        <= 1'b0;
      base_tag      <= '0;
      granted_count <= '0;
      wanted_count  <= '0;
      pasid_count   <= '0;
      range_warning <= 1'b0;
      unique case (item_kind)
        ptra_pkg::KIND_RECORD: begin
          wanted_count <= fn_valid ? rd_want : '0;
        end
        ptra_pkg::KIND_RANGE: begin
          if (fn_valid) begin
            base_tag      <= start_tab[item_idx];
            granted_count <= count_tab[item_idx];
            wanted_count  <= rd_want;
          end
          range_warning <= warn;
        end
        ptra_pkg::KIND_PASID: begin
          if (fn_valid && rd_want != '0) begin
            wanted_count <= rd_want;
            pasid_count  <= pasid_limit;
          end else begin
            status <= 1'b1;
          end
        end
        default: begin
          status <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/ptra_ctrl.sv -----
// controller: sequences item decode, the one-off assignment walk and the result load
module ptra_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ptra_pkg::ptra_stat_t stat,
  output ptra_pkg::ptra_cmd_t  cmd
);

  ptra_pkg::state_t state;
  ptra_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ptra_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.latch_item = in_valid;
        if (in_valid) begin
          state_next = ptra_pkg::ST_DECODE;
        end
      end
      ptra_pkg::ST_DECODE: begin
        if (stat.kind == ptra_pkg::KIND_RECORD) begin
          cmd.rec_write = 1'b1;
          state_next    = ptra_pkg::ST_RESP;
        end else if (stat.kind == ptra_pkg::KIND_RANGE && !stat.done) begin
          cmd.clear_acc = 1'b1;
          cmd.idx_clr   = 1'b1;
          state_next    = ptra_pkg::ST_SUM;
        end else begin
          state_next = ptra_pkg::ST_RESP;
        end
      end
      ptra_pkg::ST_SUM: begin
        cmd.sel_walk = 1'b1;
        cmd.sum_add  = 1'b1;
        if (stat.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = ptra_pkg::ST_CHECK;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ptra_pkg::ST_CHECK: begin
        cmd.sel_walk = 1'b1;
        if (stat.want_zero) begin
          // no demand: skip this function
          if (stat.idx_last) begin
            cmd.set_done = 1'b1;
            state_next   = ptra_pkg::ST_RESP;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end else if (stat.fits) begin
          cmd.grant_want = 1'b1;
          state_next     = ptra_pkg::ST_STORE;
        end else begin
          state_next = ptra_pkg::ST_MUL;
        end
      end
      ptra_pkg::ST_MUL: begin
        cmd.sel_walk = 1'b1;
        cmd.mul_load = 1'b1;
        state_next   = ptra_pkg::ST_DIV;
      end
      ptra_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ptra_pkg::ST_STORE;
        end
      end
      ptra_pkg::ST_STORE: begin
        cmd.store = 1'b1;
        if (stat.idx_last) begin
          cmd.set_done = 1'b1;
          state_next   = ptra_pkg::ST_RESP;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ptra_pkg::ST_CHECK;
        end
      end
      ptra_pkg::ST_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ptra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ptra_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
